FILE: rtl/assert_macros.svh
// assertion macros used by the rtl of the tilt transition scheduler
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define TTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tts_pkg.sv
// package of the tilt transition scheduler: codes, defaults and fixed constants
// no dependencies; used by tts_div and tilt_transition_scheduler
package tts_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DVSR_W = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HOVER_ANGLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRUISE_ANGLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENTER_SPEED  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SPEED   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SLEW_RATE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SERVO_MIN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SERVO_MAX    = 3'd6;

   // mode codes
   localparam logic [1:0] MODE_HOVER   = 2'd0;
   localparam logic [1:0] MODE_FORWARD = 2'd1;
   localparam logic [1:0] MODE_CRUISE  = 2'd2;
   localparam logic [1:0] MODE_REVERSE = 2'd3;

   // opcodes
   localparam logic OP_UPDATE    = 1'b0;
   localparam logic OP_EMERGENCY = 1'b1;

   // register reset values
   localparam logic [15:0] HOVER_ANGLE_RST  = 16'd0;
   localparam logic [15:0] CRUISE_ANGLE_RST = 16'd23040;
   localparam logic [15:0] ENTER_SPEED_RST  = 16'd2048;
   localparam logic [15:0] FULL_SPEED_RST   = 16'd3840;
   localparam logic [15:0] SLEW_RATE_RST    = 16'd7680;
   localparam logic [11:0] SERVO_MIN_RST    = 12'd1000;
   localparam logic [11:0] SERVO_MAX_RST    = 12'd2000;

   // fixed thresholds (q8.8 speeds, decimetres)
   localparam logic signed [17:0] REV_FLOOR  = 18'sd512;
   localparam logic signed [15:0] ALT_MIN_DM = 16'sd100;
   localparam logic signed [15:0] SPEED_MAX  = 16'sd8960;

   // microseconds per second and half of it for rounding
   localparam logic [DVSR_W-1:0] US_PER_S = 20'd1000000;
   localparam logic [32:0] US_HALF = 33'd500000;

endpackage

FILE: rtl/tts_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on nothing; instantiated by tilt_transition_scheduler
module tts_mul #(
   parameter int W = 18
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic done,
   output logic [2*W-1:0] product
);
   localparam int CW = $clog2(W + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [W-1:0] a_ff, a_in;
   logic [2*W:0] acc_ff, acc_in;
   logic [W:0] sum;
   logic [2*W:0] full;

   always_comb begin
      sum = {1'b0, acc_ff[2*W-1:W]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
      full = {sum, acc_ff[W-1:0]};
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in = a_ff;
      acc_in = acc_ff;
      if (start) begin
         a_in = a;
         acc_in = {{(W + 1){1'b0}}, b};
         cnt_in = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {1'b0, full[2*W:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign product = acc_ff[2*W-1:0];

endmodule

FILE: rtl/tts_div.sv
// restoring divider, one quotient bit per cycle
// uses tts_pkg; instantiated by tilt_transition_scheduler
module tts_div #(
   parameter int DW = 33
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [DW-1:0] dividend,
   input  logic [tts_pkg::DVSR_W-1:0] divisor,
   output logic done,
   output logic [DW-1:0] quotient
);
   import tts_pkg::*;

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVSR_W:0] trial;
   logic [DVSR_W:0] diff;
   logic qbit;

   always_comb begin
      trial = {rem_ff, dvd_ff[DW-1]};
      diff = trial - {1'b0, dvsr_ff};
      qbit = (trial >= {1'b0, dvsr_ff});
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dvd_in = dvd_ff;
      dvsr_in = dvsr_ff;
      rem_in = rem_ff;
      if (start) begin
         dvd_in = dividend;
         dvsr_in = divisor;
         rem_in = '0;
         cnt_in = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
         dvd_in = {dvd_ff[DW-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvsr_ff <= dvsr_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quotient = dvd_ff;

endmodule

FILE: rtl/tilt_transition_scheduler.sv
// Tilt-rotor transition scheduler: mode machine, smoothstep target, slew limit, servo pulse.
// Uses tts_pkg, tts_mul, tts_div and assert_macros.svh.
//
// usage
//  - req channel (valid/ready): one word per update step or emergency-hover command
//  - rsp channel (valid/ready): exactly one word per request word: tilt angle, servo
//    pulse, mode and transition permission
//  - csr port: write enable, register index, 16-bit data; write only while idle
//  - req_ready is high only while the sequencer is idle; one word is worked at a time
//  - the sequencer runs a bit-serial multiplier (one bit per cycle over
//    max(FRACTION_BITS+2,16) bits) and a restoring divider (one quotient bit per cycle
//    over max(FRACTION_BITS+17,33) bits); an update step uses up to two divides for
//    fractions, one divide by 10^6 and up to five multiplies
//  - the result waits in an output register; the next word is taken while the
//    receiver stalls, and its result holds in the last step until the register frees
//  - reset: synchronous, restores register defaults, mode hover, angles and progress 0
`include "assert_macros.svh"

module tilt_transition_scheduler #(
   parameter int FRACTION_BITS = tts_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // request words
   input  logic req_valid,
   output logic req_ready,
   input  logic req_opcode,
   input  logic signed [15:0] req_airspeed,
   input  logic req_manual_active,
   input  logic [15:0] req_manual_angle,
   input  logic [15:0] req_step_us,
   input  logic signed [15:0] req_altitude_dm,
   // result words
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_tilt_angle,
   output logic [11:0] rsp_pulse_us,
   output logic [1:0] rsp_mode,
   output logic rsp_may_transition,
   // register writes
   input  logic csr_we,
   input  logic [tts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tts_pkg::*;

   localparam int F = FRACTION_BITS;
   localparam int W_M = (F + 2 > 16) ? F + 2 : 16;
   localparam int DIV_W = (F + 17 > 33) ? F + 17 : 33;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_DECIDE = 13'b0000000000010,
      S_DIVP   = 13'b0000000000100,
      S_SQ     = 13'b0000000001000,
      S_CUB    = 13'b0000000010000,
      S_SCL    = 13'b0000000100000,
      S_SLM    = 13'b0000001000000,
      S_SLD    = 13'b0000010000000,
      S_NRM    = 13'b0000100000000,
      S_DIVN   = 13'b0001000000000,
      S_PUL    = 13'b0010000000000,
      S_OUT    = 13'b0100000000000,
      S_SPARE  = 13'b1000000000000
   } state_type;

   // quick-path outcome of a fraction, or magnitudes to divide
   typedef struct packed {
      logic quick;
      logic [F:0] value;
      logic [16:0] nmag;
      logic [16:0] dmag;
   } frac_type;

   function automatic frac_type frac_check(input logic signed [17:0] num,
                                           input logic signed [17:0] den);
      frac_type r;
      r.quick = 1'b1;
      r.value = '0;
      r.nmag = num[17] ? 17'(-num) : num[16:0];
      r.dmag = den[17] ? 17'(-den) : den[16:0];
      if (den == '0) begin
         r.value = ONE;
      end else if (num == '0) begin
         r.value = '0;
      end else if (num[17] != den[17]) begin
         r.value = '0;
      end else if (r.nmag >= r.dmag) begin
         r.value = ONE;
      end else begin
         r.quick = 1'b0;
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   // configuration registers
   logic [15:0] hover_ff, cruise_ff, enter_ff, full_ff, slew_ff;
   logic [11:0] smin_ff, smax_ff;

   // scheduler state
   logic [1:0] mode_ff, mode_in;
   logic [15:0] cur_ff, cur_in;
   logic [15:0] target_ff, target_in;
   logic [F:0] prog_ff, prog_in;
   logic [11:0] pulse_ff, pulse_in;

   // captured request word
   logic op_ff;
   logic signed [15:0] air_ff;
   logic man_act_ff;
   logic [15:0] man_ang_ff;
   logic [15:0] step_ff;
   logic signed [15:0] alt_ff;

   // shared arithmetic units
   logic mul_start_ff, mul_start_in;
   logic [W_M-1:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic mul_done;
   logic [2*W_M-1:0] mul_prod;
   logic div_start_ff, div_start_in;
   logic [DIV_W-1:0] div_dvd_ff, div_dvd_in;
   logic [DVSR_W-1:0] div_dvsr_ff, div_dvsr_in;
   logic div_done;
   logic [DIV_W-1:0] div_quo;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_tilt_ff, rsp_tilt_in;
   logic [11:0] rsp_pulse_ff, rsp_pulse_in;
   logic [1:0] rsp_mode_ff, rsp_mode_in;
   logic rsp_may_ff, rsp_may_in;

   // helpers
   logic signed [17:0] a18, e18, full18, span18, hov18, cru18;
   logic signed [20:0] a5, e4;
   logic [15:0] span_mag;
   logic signed [13:0] pspan;
   logic [11:0] pspan_mag;
   logic [15:0] man_clamped;
   frac_type fr_fwd, fr_rev, fr_nrm, fr_sel;
   logic [F:0] p2, s_val;
   logic [F+1:0] k_val;
   logic [15:0] m16;
   logic [11:0] m12;
   logic [13:0] md;
   logic signed [18:0] delta, md19, moved, hov19, cru19;
   logic may_now;

   assign a18 = 18'(air_ff);
   assign e18 = {2'b00, enter_ff};
   assign full18 = {2'b00, full_ff};
   assign hov18 = {2'b00, hover_ff};
   assign cru18 = {2'b00, cruise_ff};
   assign span18 = cru18 - hov18;
   assign span_mag = span18[17] ? 16'(-span18) : span18[15:0];
   assign pspan = {2'b00, smax_ff} - {2'b00, smin_ff};
   assign pspan_mag = pspan[13] ? 12'(-pspan) : pspan[11:0];
   assign a5 = (21'(air_ff) <<< 2) + 21'(air_ff);
   assign e4 = {3'b000, enter_ff, 2'b00};
   assign man_clamped = (man_ang_ff < hover_ff) ? hover_ff :
                        (man_ang_ff > cruise_ff) ? cruise_ff : man_ang_ff;
   assign fr_fwd = frac_check(a18 - e18, full18 - e18);
   assign fr_rev = frac_check(a18 - REV_FLOOR, e18 - REV_FLOOR);
   assign fr_nrm = frac_check({2'b00, cur_ff} - hov18, span18);
   assign fr_sel = (mode_ff == MODE_FORWARD) ? fr_fwd : fr_rev;
   assign p2 = mul_prod[2*F:F];
   assign s_val = mul_prod[2*F:F];
   assign k_val = {2'b11, {F{1'b0}}} - {prog_ff, 1'b0};
   assign m16 = mul_prod[F+15:F];
   assign m12 = mul_prod[F+11:F];
   assign md = div_quo[13:0];
   assign hov19 = {3'b000, hover_ff};
   assign cru19 = {3'b000, cruise_ff};
   assign md19 = {5'b00000, md};
   assign delta = {3'b000, target_ff} - {3'b000, cur_ff};
   assign moved = (delta > md19) ? {3'b000, cur_ff} + md19 :
                  (delta < -md19) ? {3'b000, cur_ff} - md19 : {3'b000, target_ff};
   assign may_now = !(alt_ff < ALT_MIN_DM || air_ff < 16'sd0 || air_ff > SPEED_MAX ||
                      (mode_ff == MODE_CRUISE && a18 > e18));

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      cur_in = cur_ff;
      target_in = target_ff;
      prog_in = prog_ff;
      pulse_in = pulse_ff;
      mul_start_in = 1'b0;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      div_start_in = 1'b0;
      div_dvd_in = div_dvd_ff;
      div_dvsr_in = div_dvsr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_tilt_in = rsp_tilt_ff;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_mode_in = rsp_mode_ff;
      rsp_may_in = rsp_may_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // slew product is the default next step
            mul_a_in = W_M'(slew_ff);
            mul_b_in = W_M'(step_ff);
            mul_start_in = 1'b1;
            state_in = S_SLM;
            if (op_ff == OP_EMERGENCY) begin
               mode_in = MODE_REVERSE;
               target_in = hover_ff;
               prog_in = '0;
               mul_start_in = 1'b0;
               state_in = S_NRM;
            end else if (man_act_ff) begin
               target_in = man_clamped;
            end else if (mode_ff == MODE_HOVER) begin
               target_in = hover_ff;
               if (a18 > e18) begin
                  mode_in = MODE_FORWARD;
                  prog_in = '0;
               end
            end else if (mode_ff == MODE_CRUISE) begin
               target_in = cruise_ff;
               if (a18 < e18) begin
                  mode_in = MODE_REVERSE;
                  prog_in = ONE;
               end
            end else begin
               // transition modes: progress then smoothstep curve
               mul_start_in = 1'b1;
               state_in = S_SQ;
               if (mode_ff == MODE_FORWARD && a18 >= full18) begin
                  prog_in = ONE;
                  mode_in = MODE_CRUISE;
               end else if (mode_ff == MODE_FORWARD && a5 < e4) begin
                  mode_in = MODE_REVERSE;
               end else if (mode_ff == MODE_REVERSE && a18 <= REV_FLOOR) begin
                  prog_in = '0;
                  mode_in = MODE_HOVER;
               end else if (fr_sel.quick) begin
                  prog_in = fr_sel.value;
               end else begin
                  mul_start_in = 1'b0;
                  div_dvd_in = DIV_W'({fr_sel.nmag, {F{1'b0}}});
                  div_dvsr_in = DVSR_W'(fr_sel.dmag);
                  div_start_in = 1'b1;
                  state_in = S_DIVP;
               end
               mul_a_in = W_M'(prog_in);
               mul_b_in = W_M'(prog_in);
            end
         end
         S_DIVP: begin
            if (div_done) begin
               prog_in = {1'b0, div_quo[F-1:0]};
               mul_a_in = W_M'(prog_in);
               mul_b_in = W_M'(prog_in);
               mul_start_in = 1'b1;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (mul_done) begin
               mul_a_in = W_M'(p2);
               mul_b_in = W_M'(k_val);
               mul_start_in = 1'b1;
               state_in = S_CUB;
            end
         end
         S_CUB: begin
            if (mul_done) begin
               mul_a_in = W_M'(s_val);
               mul_b_in = W_M'(span_mag);
               mul_start_in = 1'b1;
               state_in = S_SCL;
            end
         end
         S_SCL: begin
            if (mul_done) begin
               target_in = span18[17] ? hover_ff - m16 : hover_ff + m16;
               mul_a_in = W_M'(slew_ff);
               mul_b_in = W_M'(step_ff);
               mul_start_in = 1'b1;
               state_in = S_SLM;
            end
         end
         S_SLM: begin
            if (mul_done) begin
               div_dvd_in = DIV_W'({1'b0, mul_prod[31:0]} + US_HALF);
               div_dvsr_in = US_PER_S;
               div_start_in = 1'b1;
               state_in = S_SLD;
            end
         end
         S_SLD: begin
            if (div_done) begin
               cur_in = (moved < hov19) ? hover_ff :
                        (moved > cru19) ? cruise_ff : moved[15:0];
               state_in = S_NRM;
            end
         end
         S_NRM: begin
            if (fr_nrm.quick) begin
               mul_a_in = W_M'(fr_nrm.value);
               mul_b_in = W_M'(pspan_mag);
               mul_start_in = 1'b1;
               state_in = S_PUL;
            end else begin
               div_dvd_in = DIV_W'({fr_nrm.nmag, {F{1'b0}}});
               div_dvsr_in = DVSR_W'(fr_nrm.dmag);
               div_start_in = 1'b1;
               state_in = S_DIVN;
            end
         end
         S_DIVN: begin
            if (div_done) begin
               mul_a_in = W_M'(div_quo[F-1:0]);
               mul_b_in = W_M'(pspan_mag);
               mul_start_in = 1'b1;
               state_in = S_PUL;
            end
         end
         S_PUL: begin
            if (mul_done) begin
               pulse_in = pspan[13] ? smin_ff - m12 : smin_ff + m12;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold here while the previous word is still unread
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_tilt_in = cur_ff;
               rsp_pulse_in = pulse_ff;
               rsp_mode_in = mode_ff;
               rsp_may_in = may_now;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hover_ff <= HOVER_ANGLE_RST;
         cruise_ff <= CRUISE_ANGLE_RST;
         enter_ff <= ENTER_SPEED_RST;
         full_ff <= FULL_SPEED_RST;
         slew_ff <= SLEW_RATE_RST;
         smin_ff <= SERVO_MIN_RST;
         smax_ff <= SERVO_MAX_RST;
         mode_ff <= MODE_HOVER;
         cur_ff <= '0;
         target_ff <= '0;
         prog_ff <= '0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         cur_ff <= cur_in;
         target_ff <= target_in;
         prog_ff <= prog_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_HOVER_ANGLE:  hover_ff <= csr_wdata;
               REG_CRUISE_ANGLE: cruise_ff <= csr_wdata;
               REG_ENTER_SPEED:  enter_ff <= csr_wdata;
               REG_FULL_SPEED:   full_ff <= csr_wdata;
               REG_SLEW_RATE:    slew_ff <= csr_wdata;
               REG_SERVO_MIN:    smin_ff <= csr_wdata[11:0];
               REG_SERVO_MAX:    smax_ff <= csr_wdata[11:0];
               default: begin
               end
            endcase
         end
      end
      // payload, no reset
      if (req_valid && req_ready) begin
         op_ff <= req_opcode;
         air_ff <= req_airspeed;
         man_act_ff <= req_manual_active;
         man_ang_ff <= req_manual_angle;
         step_ff <= req_step_us;
         alt_ff <= req_altitude_dm;
      end
      pulse_ff <= pulse_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      div_dvd_ff <= div_dvd_in;
      div_dvsr_ff <= div_dvsr_in;
      rsp_tilt_ff <= rsp_tilt_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_mode_ff <= rsp_mode_in;
      rsp_may_ff <= rsp_may_in;
   end

   // shared serial units
   tts_mul #(.W(W_M)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mul_a_ff),
      .b       (mul_b_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   tts_div #(.DW(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dvd_ff),
      .divisor  (div_dvsr_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_tilt_angle = rsp_tilt_ff;
   assign rsp_pulse_us = rsp_pulse_ff;
   assign rsp_mode = rsp_mode_ff;
   assign rsp_may_transition = rsp_may_ff;

   // checks
   `TTS_ASSERT(a_accept_decode, clock, reset, (req_valid && req_ready) |=> (state_ff == S_DECIDE), "accepted word not decoded")
   `TTS_ASSERT(a_units_exclusive, clock, reset, !(mul_done && div_done), "multiplier and divider finished together")
   `TTS_ASSERT(a_idle_units_quiet, clock, reset, (state_ff == S_IDLE) |-> (!mul_done && !div_done), "arithmetic unit finished while idle")
   `TTS_ASSERT_ALWAYS(a_reset_clean, clock, $past(reset) |-> (state_ff == S_IDLE && !rsp_valid_ff), "state not cleared by reset")

endmodule
